// ----- rtl/cvfm_pkg.sv -----
// ----------------------------------------------------------------------------
// cvfm_pkg: shared types and constants for the cell voltage fault monitor
// Register indexes, reset values, request/result structs, counter helpers.
// ----------------------------------------------------------------------------
package cvfm_pkg;

    localparam int NUM_TAPS       = 32;
    localparam int CHARGE_HYST_MV = 50;
    localparam int REGEN_HYST_MV  = 50;

    localparam int TAP_IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam logic [31:0] ALL_TAPS_MASK = 32'((64'd1 << NUM_TAPS) - 64'd1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0]  CNT_MAX = 8'd255;
    localparam logic [20:0] SUM_MAX = 21'h1FFFFF;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_OVER_LIMIT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REGEN_LIMIT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RELAX_MODE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OVER_MASK    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_UNDER_MASK   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CHIP_MASK    = 3'd7;

    // register reset values
    localparam logic [15:0] RST_OVER_LIMIT   = 16'd4200;
    localparam logic [15:0] RST_CHARGE_LIMIT = 16'd4150;
    localparam logic [15:0] RST_REGEN_LIMIT  = 16'd4100;
    localparam logic [7:0]  RST_THRESHOLD    = 8'd3;

    // tap classification
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    // board diagnostic codes that count as chip faults
    localparam logic [1:0] BC_READ_ERR = 2'd1;
    localparam logic [1:0] BC_OOB      = 2'd2;

    typedef struct packed {
        logic [15:0] over_limit_mv;
        logic [15:0] charge_limit_mv;
        logic [15:0] regen_limit_mv;
        logic [7:0]  fault_threshold;
        logic        relax_mode;
        logic [31:0] over_mask;
        logic [31:0] under_mask;
        logic [31:0] chip_mask;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [4:0]  tap_sel;
        logic [15:0] tap_mv;
        logic [1:0]  board_code;
        logic        tap_fresh;
        logic        scan_last;
        logic [1:0]  status;
    } t_work;

    typedef struct packed {
        logic [1:0]  tap_status;
        logic        over_event;
        logic        under_event;
        logic        chip_event;
        logic        scan_done;
        logic [15:0] max_cell_mv;
        logic [15:0] min_cell_mv;
        logic [20:0] pack_mv;
        logic        charge_ok;
        logic        regen_ok;
        logic        monitor_good;
    } t_result;

    function automatic logic [7:0] bump_cnt(input logic [7:0] c);
        return (c < CNT_MAX) ? c + 8'd1 : c;
    endfunction

    function automatic logic [7:0] relax_cnt(input logic [7:0] c, input logic mode);
        logic [7:0] r;
        if (mode) begin
            r = 8'd0;
        end else if (c != 8'd0) begin
            r = c - 8'd1;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

// ----- rtl/cvfm_cfg.sv -----
// ----------------------------------------------------------------------------
// cvfm_cfg: configuration register file
// Write-only registers, one per index, reset to their defaults.
// ----------------------------------------------------------------------------
module cvfm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cvfm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [cvfm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output cvfm_pkg::t_cfg                    o_cfg
);

    cvfm_pkg::t_cfg r_cfg;
    cvfm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                cvfm_pkg::REG_OVER_LIMIT:   n_cfg.over_limit_mv   = i_cfg_wdata[15:0];
                cvfm_pkg::REG_CHARGE_LIMIT: n_cfg.charge_limit_mv = i_cfg_wdata[15:0];
                cvfm_pkg::REG_REGEN_LIMIT:  n_cfg.regen_limit_mv  = i_cfg_wdata[15:0];
                cvfm_pkg::REG_THRESHOLD:    n_cfg.fault_threshold = i_cfg_wdata[7:0];
                cvfm_pkg::REG_RELAX_MODE:   n_cfg.relax_mode      = i_cfg_wdata[0];
                cvfm_pkg::REG_OVER_MASK:    n_cfg.over_mask       = i_cfg_wdata[31:0];
                cvfm_pkg::REG_UNDER_MASK:   n_cfg.under_mask      = i_cfg_wdata[31:0];
                cvfm_pkg::REG_CHIP_MASK:    n_cfg.chip_mask       = i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_limit_mv   <= cvfm_pkg::RST_OVER_LIMIT;
            r_cfg.charge_limit_mv <= cvfm_pkg::RST_CHARGE_LIMIT;
            r_cfg.regen_limit_mv  <= cvfm_pkg::RST_REGEN_LIMIT;
            r_cfg.fault_threshold <= cvfm_pkg::RST_THRESHOLD;
            r_cfg.relax_mode      <= 1'b0;
            r_cfg.over_mask       <= 32'd0;
            r_cfg.under_mask      <= 32'd0;
            r_cfg.chip_mask       <= 32'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/cvfm_front.sv -----
// ----------------------------------------------------------------------------
// cvfm_front: sample intake and classification
// Classifies each sample against the limits and parks it in a 2-entry queue.
// ----------------------------------------------------------------------------
module cvfm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cvfm_pkg::t_cfg      i_cfg,
    input  logic                i_push,
    input  logic [4:0]          i_tap_sel,
    input  logic [15:0]         i_tap_mv,
    input  logic [1:0]          i_board_code,
    input  logic                i_tap_fresh,
    input  logic [15:0]         i_under_limit_mv,
    input  logic                i_scan_last,
    output logic                o_full,
    output logic                o_work_valid,
    output cvfm_pkg::t_work     o_work,
    input  logic                i_work_pop
);

    cvfm_pkg::t_work r_q [2];
    cvfm_pkg::t_work n_work;
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_cnt;
    logic            w_push_ok;
    logic            w_pop_ok;

    always_comb begin
        n_work.tap_sel    = i_tap_sel;
        n_work.tap_mv     = i_tap_mv;
        n_work.board_code = i_board_code;
        n_work.tap_fresh  = i_tap_fresh;
        n_work.scan_last  = i_scan_last;
        if (i_tap_mv > i_cfg.over_limit_mv) begin
            n_work.status = cvfm_pkg::ST_OVER;
        end else if (i_tap_mv < i_under_limit_mv) begin
            n_work.status = cvfm_pkg::ST_UNDER;
        end else begin
            n_work.status = cvfm_pkg::ST_OK;
        end
    end

    assign o_full       = (r_cnt == 2'd2);
    assign o_work_valid = (r_cnt != 2'd0);
    assign o_work       = r_q[r_rd_ptr];
    assign w_push_ok    = i_push && !o_full;
    assign w_pop_ok     = i_work_pop && o_work_valid;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr_ptr] <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("front queue count out of range");

endmodule

// ----- rtl/cvfm_back.sv -----
// ----------------------------------------------------------------------------
// cvfm_back: fault debounce and scan summary
// Per-tap counters, events, running aggregates, gates, 2-entry result queue.
// ----------------------------------------------------------------------------
module cvfm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cvfm_pkg::t_cfg      i_cfg,
    input  logic                i_work_valid,
    input  cvfm_pkg::t_work     i_work,
    output logic                o_work_pop,
    output logic                o_empty,
    output cvfm_pkg::t_result   o_result,
    input  logic                i_pop
);

    logic [7:0]  r_level [cvfm_pkg::NUM_TAPS];
    logic [7:0]  r_chip  [cvfm_pkg::NUM_TAPS];
    logic [31:0] r_seen;
    logic [15:0] r_max;
    logic [15:0] r_min;
    logic [20:0] r_sum;
    logic [1:0]  r_flags;   // [0] all good, [1] debounce clear
    logic [2:0]  r_gate;    // [0] charge ok, [1] regen ok, [2] monitor good

    cvfm_pkg::t_result r_oq [2];
    logic              r_owr;
    logic              r_ord;
    logic [1:0]        r_ocnt;

    logic                              w_go;
    logic                              w_tap_ok;
    logic [cvfm_pkg::TAP_IDX_W-1:0]    w_idx;
    logic                              w_chip_bad;
    logic                              w_lvl_bad;
    logic [7:0]                        w_chip_old;
    logic [7:0]                        w_lvl_old;
    logic [7:0]                        n_chip;
    logic [7:0]                        n_level;
    logic                              w_chip_ev;
    logic                              w_over_ev;
    logic                              w_under_ev;
    logic [31:0]                       n_seen;
    logic [1:0]                        w_flags;
    logic [15:0]                       w_max;
    logic [15:0]                       w_min;
    logic [21:0]                       w_sum_raw;
    logic [20:0]                       w_sum;
    logic [2:0]                        n_gate;
    cvfm_pkg::t_result                 n_result;
    logic                              w_opop;

    assign o_empty    = (r_ocnt == 2'd0);
    assign o_result   = r_oq[r_ord];
    assign w_opop     = i_pop && !o_empty;
    assign w_go       = i_work_valid && (r_ocnt != 2'd2);
    assign o_work_pop = w_go;

    assign w_tap_ok   = ({1'b0, i_work.tap_sel} < 6'(cvfm_pkg::NUM_TAPS));
    assign w_idx      = i_work.tap_sel[cvfm_pkg::TAP_IDX_W-1:0];
    assign w_chip_bad = (i_work.board_code == cvfm_pkg::BC_READ_ERR) ||
                        (i_work.board_code == cvfm_pkg::BC_OOB);
    assign w_lvl_bad  = (i_work.status != cvfm_pkg::ST_OK);
    assign w_chip_old = r_chip[w_idx];
    assign w_lvl_old  = r_level[w_idx];

    always_comb begin
        n_chip  = w_chip_bad ? cvfm_pkg::bump_cnt(w_chip_old)
                             : cvfm_pkg::relax_cnt(w_chip_old, i_cfg.relax_mode);
        n_level = w_lvl_bad ? cvfm_pkg::bump_cnt(w_lvl_old)
                            : cvfm_pkg::relax_cnt(w_lvl_old, i_cfg.relax_mode);

        w_chip_ev  = w_tap_ok && w_chip_bad && (n_chip >= i_cfg.fault_threshold) &&
                     !i_cfg.chip_mask[i_work.tap_sel];
        w_over_ev  = w_tap_ok && (i_work.status == cvfm_pkg::ST_OVER) &&
                     (n_level >= i_cfg.fault_threshold) &&
                     !i_cfg.over_mask[i_work.tap_sel];
        w_under_ev = w_tap_ok && (i_work.status == cvfm_pkg::ST_UNDER) &&
                     (n_level >= i_cfg.fault_threshold) &&
                     !i_cfg.under_mask[i_work.tap_sel];

        n_seen = r_seen;
        if (w_tap_ok && i_work.tap_fresh) begin
            n_seen[i_work.tap_sel] = 1'b1;
        end

        w_flags = r_flags;
        if (w_chip_ev || w_over_ev || w_under_ev) begin
            w_flags[0] = 1'b0;
        end
        if (w_tap_ok && ((n_level != 8'd0) || (n_chip != 8'd0))) begin
            w_flags[1] = 1'b0;
        end

        w_max     = (i_work.tap_mv > r_max) ? i_work.tap_mv : r_max;
        w_min     = (i_work.tap_mv < r_min) ? i_work.tap_mv : r_min;
        w_sum_raw = {1'b0, r_sum} + {6'd0, i_work.tap_mv};
        w_sum     = (w_sum_raw > {1'b0, cvfm_pkg::SUM_MAX}) ? cvfm_pkg::SUM_MAX
                                                           : w_sum_raw[20:0];

        // charge/regen gate hysteresis on the scan max, and the monitor-good latch, evaluated at scan end
        n_gate = r_gate;
        if (i_work.scan_last) begin
            if ((w_max >= i_cfg.charge_limit_mv) && r_gate[0]) begin
                n_gate[0] = 1'b0;
            end else if ((({1'b0, w_max} + 17'(cvfm_pkg::CHARGE_HYST_MV)) <
                          {1'b0, i_cfg.charge_limit_mv}) && !r_gate[0]) begin
                n_gate[0] = 1'b1;
            end
            if ((w_max >= i_cfg.regen_limit_mv) && r_gate[1]) begin
                n_gate[1] = 1'b0;
            end else if ((({1'b0, w_max} + 17'(cvfm_pkg::REGEN_HYST_MV)) <
                          {1'b0, i_cfg.regen_limit_mv}) && !r_gate[1]) begin
                n_gate[1] = 1'b1;
            end
            if ((w_flags == 2'b11) &&
                ((n_seen & cvfm_pkg::ALL_TAPS_MASK) == cvfm_pkg::ALL_TAPS_MASK)) begin
                n_gate[2] = 1'b1;
            end
        end

        n_result.tap_status   = i_work.status;
        n_result.over_event   = w_over_ev;
        n_result.under_event  = w_under_ev;
        n_result.chip_event   = w_chip_ev;
        n_result.scan_done    = i_work.scan_last;
        n_result.max_cell_mv  = i_work.scan_last ? w_max : 16'd0;
        n_result.min_cell_mv  = i_work.scan_last ? w_min : 16'd0;
        n_result.pack_mv      = i_work.scan_last ? w_sum : 21'd0;
        n_result.charge_ok    = n_gate[0];
        n_result.regen_ok     = n_gate[1];
        n_result.monitor_good = n_gate[2];
    end

    // per-tap counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cvfm_pkg::NUM_TAPS; i++) begin
                r_level[i] <= 8'd0;
                r_chip[i]  <= 8'd0;
            end
        end else if (w_go && w_tap_ok) begin
            r_level[w_idx] <= n_level;
            r_chip[w_idx]  <= n_chip;
        end
    end

    // scan state and gates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 32'd0;
            r_max   <= 16'd0;
            r_min   <= 16'hFFFF;
            r_sum   <= 21'd0;
            r_flags <= 2'b11;
            r_gate  <= 3'b011;
        end else if (w_go) begin
            r_seen <= n_seen;
            r_gate <= n_gate;
            if (i_work.scan_last) begin
                r_max   <= 16'd0;
                r_min   <= 16'hFFFF;
                r_sum   <= 21'd0;
                r_flags <= 2'b11;
            end else begin
                r_max   <= w_max;
                r_min   <= w_min;
                r_sum   <= w_sum;
                r_flags <= w_flags;
            end
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_oq[r_owr] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_go) begin
                r_owr <= !r_owr;
            end
            if (w_opop) begin
                r_ord <= !r_ord;
            end
            case ({w_go, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    a_monitor_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate[2] |=> r_gate[2])
        else $error("monitor good latch dropped");

    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && i_work.scan_last) |=>
            (r_max == 16'd0 && r_min == 16'hFFFF && r_sum == 21'd0 && r_flags == 2'b11))
        else $error("scan state not restarted after scan end");

    a_chip_ev_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_chip_ev) |-> (w_tap_ok && n_chip != 8'd0 &&
            (i_work.board_code == cvfm_pkg::BC_READ_ERR ||
             i_work.board_code == cvfm_pkg::BC_OOB)))
        else $error("chip event without chip fault");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt == 2'd2) |-> !w_go)
        else $error("result queue overrun");

endmodule

// ----- rtl/cell_voltage_fault_monitor_top.sv -----
// ----------------------------------------------------------------------------
// cell_voltage_fault_monitor_top: cell tap fault debouncer and scan summarizer
// Usage:
//   Input queue: drive a sample on i_tap_* / i_board_code / i_under_limit_mv /
//   i_scan_last and raise push; the request is taken at an edge with push high
//   and full low. Result queue: while empty is low the oldest result sits on
//   the o_* ports; it is taken at an edge with pop high.
//   One result per request, in order. The front classifies and queues the
//   request at the accept edge; the back, once its result queue has room,
//   updates the tap's counters and the scan aggregates and queues the result.
//   Throughput is one request per cycle while the result queue has room,
//   set by the counter read-modify-write in the back.
//   Each side has a 2-entry queue, so a stalled reader first fills the result
//   queue, then the front queue, and only then raises full.
//   Configuration: i_cfg_we / i_cfg_addr / i_cfg_wdata write one register per
//   cycle; write only while no request is in flight.
//   Reset (i_rst_n low, synchronous) clears counters, queues and scan state and
//   loads register defaults; charge and regen gates start open.
// ----------------------------------------------------------------------------
module cell_voltage_fault_monitor_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [cvfm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [cvfm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // sample input
    input  logic                             push,
    output logic                             full,
    input  logic [4:0]                       i_tap_sel,
    input  logic [15:0]                      i_tap_mv,
    input  logic [1:0]                       i_board_code,
    input  logic                             i_tap_fresh,
    input  logic [15:0]                      i_under_limit_mv,
    input  logic                             i_scan_last,
    // results
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       o_tap_status,
    output logic                             o_over_event,
    output logic                             o_under_event,
    output logic                             o_chip_event,
    output logic                             o_scan_done,
    output logic [15:0]                      o_max_cell_mv,
    output logic [15:0]                      o_min_cell_mv,
    output logic [20:0]                      o_pack_mv,
    output logic                             o_charge_ok,
    output logic                             o_regen_ok,
    output logic                             o_monitor_good
);

    cvfm_pkg::t_cfg    w_cfg;
    cvfm_pkg::t_work   w_work;
    cvfm_pkg::t_result w_result;
    logic              w_work_valid;
    logic              w_work_pop;

    cvfm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // front: classify against over limit and per-request under limit
    cvfm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_push           (push),
        .i_tap_sel        (i_tap_sel),
        .i_tap_mv         (i_tap_mv),
        .i_board_code     (i_board_code),
        .i_tap_fresh      (i_tap_fresh),
        .i_under_limit_mv (i_under_limit_mv),
        .i_scan_last      (i_scan_last),
        .o_full           (full),
        .o_work_valid     (w_work_valid),
        .o_work           (w_work),
        .i_work_pop       (w_work_pop)
    );

    // back: debounce counters, events, scan summary, gates
    cvfm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_pop   (w_work_pop),
        .o_empty      (empty),
        .o_result     (w_result),
        .i_pop        (pop)
    );

    assign o_tap_status   = w_result.tap_status;
    assign o_over_event   = w_result.over_event;
    assign o_under_event  = w_result.under_event;
    assign o_chip_event   = w_result.chip_event;
    assign o_scan_done    = w_result.scan_done;
    assign o_max_cell_mv  = w_result.max_cell_mv;
    assign o_min_cell_mv  = w_result.min_cell_mv;
    assign o_pack_mv      = w_result.pack_mv;
    assign o_charge_ok    = w_result.charge_ok;
    assign o_regen_ok     = w_result.regen_ok;
    assign o_monitor_good = w_result.monitor_good;

endmodule
